>>> design/pba_pkg.sv
// ============================================================================
// pba_pkg: shared definitions for the page bump allocator
// Field widths, pool geometry, command and status codes, the page table
// entry layout and the control and status bundles between controller and
// datapath.
// ============================================================================
package pba_pkg;

   // Pool geometry.
   localparam int NUM_PAGES_DEF = 16;
   localparam int PAGE_BYTES    = 4096;
   localparam int ALIGN_BYTES   = 16;
   localparam int PAGE_HEADER   = 32;
   localparam int FIRST_HEADER  = 56;
   localparam int FAIL_LIMIT    = 4;

   // Port field widths.
   localparam int CMD_W    = 2;
   localparam int SIZE_W   = 12;
   localparam int ADDR_W   = 16;
   localparam int STATUS_W = 3;
   localparam int INDEX_W  = 4;

   // Page table entry widths. The offset carries one extra bit for rounding.
   localparam int FILL_W  = 13;
   localparam int REFS_W  = 9;
   localparam int FAILS_W = 3;
   localparam int OFF_W   = FILL_W + 1;

   localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
   localparam int PAGE_NUM_W = ADDR_W - PAGE_SHIFT;

   // Offset of the first block in a freshly opened page.
   localparam int FIRST_OFF   = ((PAGE_HEADER + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
   localparam bit HEADER_FITS = (FIRST_OFF <= PAGE_BYTES);
   localparam int MAX_ALLOC   = HEADER_FITS ? (PAGE_BYTES - FIRST_OFF) : 0;

   localparam logic [REFS_W-1:0]  REFS_MAX  = '1;
   localparam logic [FAILS_W-1:0] FAILS_MAX = '1;

   typedef enum logic [CMD_W-1:0] {
      CMD_ALLOC = 2'd0,
      CMD_FREE  = 2'd1,
      CMD_RESET = 2'd2
   } command_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 3'd0,
      ST_ZERO_SIZE = 3'd1,
      ST_TOO_LARGE = 3'd2,
      ST_NO_PAGES  = 3'd3,
      ST_BAD_FREE  = 3'd4
   } status_type;

   typedef struct packed {
      logic [FILL_W-1:0]  fill;
      logic [REFS_W-1:0]  refs;
      logic [FAILS_W-1:0] fails;
   } page_entry_type;

   // Controller to datapath.
   typedef struct packed {
      logic       accept;
      logic       ptr_inc;
      logic       age_init;
      logic       hit_wr;
      logic       age_wr;
      logic       open_wr;
      logic       free_wr;
      logic       clear_wr;
      logic       start_clr;
      logic       res_set;
      status_type res_code;
      logic       rsp_load;
   } ctrl_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic size_zero;
      logic too_large;
      logic chain_done;
      logic fits;
      logic scan_last;
      logic pool_full;
      logic age_none;
      logic age_last;
      logic free_bad;
      logic refs_zero;
      logic clear_last;
      logic rsp_free;
   } dp_status_type;

   // Rounds a fill offset up to the alignment grain.
   function automatic logic [OFF_W-1:0] round_up(input logic [FILL_W-1:0] n);
      logic [OFF_W-1:0] sum;
      sum = OFF_W'(n) + OFF_W'(ALIGN_BYTES - 1);
      return OFF_W'((sum / ALIGN_BYTES) * ALIGN_BYTES);
   endfunction

   // Fill offset of an emptied page; the first page has a larger header.
   function automatic logic [FILL_W-1:0] empty_fill(input logic is_first);
      return is_first ? FILL_W'(FIRST_HEADER) : FILL_W'(PAGE_HEADER);
   endfunction

endpackage

>>> design/pba_ctrl.sv
// ============================================================================
// pba_ctrl: sequencing state machine of the page bump allocator
// Walks one command at a time through check, scan, aging, open, free and
// clear steps, and hands each finished result to the output register.
// ============================================================================
module pba_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic [pba_pkg::CMD_W-1:0] req_command,
   output logic                  req_stall,
   input  pba_pkg::dp_status_type dp_status,
   output pba_pkg::ctrl_cmd_type  ctrl_cmd
);
   import pba_pkg::*;

   typedef enum logic [10:0] {
      S_IDLE     = 11'b000_0000_0001,
      S_A_CHK    = 11'b000_0000_0010,
      S_A_SCAN   = 11'b000_0000_0100,
      S_A_MISS   = 11'b000_0000_1000,
      S_A_AGE_RD = 11'b000_0001_0000,
      S_A_AGE    = 11'b000_0010_0000,
      S_A_OPEN   = 11'b000_0100_0000,
      S_F_CHK    = 11'b000_1000_0000,
      S_F_UPD    = 11'b001_0000_0000,
      S_R_RUN    = 11'b010_0000_0000,
      S_DONE     = 11'b100_0000_0000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      ctrl_cmd = '0;
      ctrl_cmd.res_code = ST_OK;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ctrl_cmd.accept = 1'b1;
               case (req_command)
                  CMD_ALLOC: state_in = S_A_CHK;
                  CMD_FREE:  state_in = S_F_CHK;
                  CMD_RESET: state_in = S_R_RUN;
                  default:   state_in = S_DONE;
               endcase
            end
         end
         S_A_CHK: begin
            if (dp_status.size_zero) begin
               ctrl_cmd.res_set  = 1'b1;
               ctrl_cmd.res_code = ST_ZERO_SIZE;
               state_in = S_DONE;
            end else if (dp_status.too_large) begin
               ctrl_cmd.res_set  = 1'b1;
               ctrl_cmd.res_code = ST_TOO_LARGE;
               state_in = S_DONE;
            end else if (dp_status.chain_done) begin
               state_in = S_A_MISS;
            end else begin
               ctrl_cmd.ptr_inc = 1'b1;
               state_in = S_A_SCAN;
            end
         end
         S_A_SCAN: begin
            if (dp_status.fits) begin
               ctrl_cmd.hit_wr = 1'b1;
               state_in = S_DONE;
            end else if (dp_status.scan_last) begin
               state_in = S_A_MISS;
            end else begin
               ctrl_cmd.ptr_inc = 1'b1;
            end
         end
         S_A_MISS: begin
            if (dp_status.pool_full) begin
               ctrl_cmd.res_set  = 1'b1;
               ctrl_cmd.res_code = ST_NO_PAGES;
               state_in = S_DONE;
            end else if (dp_status.age_none) begin
               state_in = S_A_OPEN;
            end else begin
               ctrl_cmd.age_init = 1'b1;
               state_in = S_A_AGE_RD;
            end
         end
         S_A_AGE_RD: begin
            ctrl_cmd.ptr_inc = 1'b1;
            state_in = S_A_AGE;
         end
         S_A_AGE: begin
            ctrl_cmd.age_wr = 1'b1;
            if (dp_status.age_last) begin
               state_in = S_A_OPEN;
            end else begin
               ctrl_cmd.ptr_inc = 1'b1;
            end
         end
         S_A_OPEN: begin
            ctrl_cmd.open_wr = 1'b1;
            state_in = S_DONE;
         end
         S_F_CHK: begin
            if (dp_status.free_bad) begin
               ctrl_cmd.res_set  = 1'b1;
               ctrl_cmd.res_code = ST_BAD_FREE;
               state_in = S_DONE;
            end else begin
               state_in = S_F_UPD;
            end
         end
         S_F_UPD: begin
            if (dp_status.refs_zero) begin
               ctrl_cmd.res_set  = 1'b1;
               ctrl_cmd.res_code = ST_BAD_FREE;
            end else begin
               ctrl_cmd.free_wr = 1'b1;
            end
            state_in = S_DONE;
         end
         S_R_RUN: begin
            ctrl_cmd.clear_wr = 1'b1;
            if (dp_status.clear_last) begin
               ctrl_cmd.start_clr = 1'b1;
               state_in = S_DONE;
            end else begin
               ctrl_cmd.ptr_inc = 1'b1;
            end
         end
         S_DONE: begin
            if (dp_status.rsp_free) begin
               ctrl_cmd.rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

>>> design/pba_datapath.sv
// ============================================================================
// pba_datapath: page table and arithmetic of the page bump allocator
// Holds the page table memory, chain length, search start, walk pointer,
// alignment and fit logic, and the result output register.
// ============================================================================
module pba_datapath #(
   parameter int NUM_PAGES = pba_pkg::NUM_PAGES_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [pba_pkg::CMD_W-1:0]  req_command,
   input  logic [pba_pkg::SIZE_W-1:0] req_alloc_size,
   input  logic [pba_pkg::ADDR_W-1:0] req_free_addr,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [pba_pkg::STATUS_W-1:0] rsp_status,
   output logic [pba_pkg::ADDR_W-1:0] rsp_result_addr,
   output logic [pba_pkg::INDEX_W-1:0] rsp_current_index,
   input  pba_pkg::ctrl_cmd_type      ctrl_cmd,
   output pba_pkg::dp_status_type     dp_status
);
   import pba_pkg::*;

   localparam int IDX_W = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
   localparam int PU_W  = $clog2(NUM_PAGES + 1);

   localparam page_entry_type FRESH_ENTRY = '{
      fill:  FILL_W'(FIRST_HEADER),
      refs:  '0,
      fails: '0
   };

   // Page table: one port written, one read, read data registered.
   page_entry_type mem [NUM_PAGES];
   page_entry_type rd_data_ff;
   logic [IDX_W-1:0] rd_idx_ff;
   logic rd_fresh_ff;
   logic page0_fresh_ff;

   logic [IDX_W-1:0] ptr_ff;
   logic [IDX_W-1:0] cur_ff;
   logic [IDX_W-1:0] search_start_ff;
   logic [PU_W-1:0]  pages_used_ff;
   logic [SIZE_W-1:0] size_ff;
   logic [ADDR_W-1:0] faddr_ff;
   status_type        res_status_ff;
   logic [ADDR_W-1:0] res_addr_ff;

   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [ADDR_W-1:0]   rsp_addr_ff;
   logic [INDEX_W-1:0]  rsp_index_ff;

   page_entry_type   rd_eff;
   logic [OFF_W-1:0] off;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   page_entry_type   wr_data;
   logic [PAGE_NUM_W-1:0] req_page;
   logic [PAGE_NUM_W-1:0] free_page;
   logic [IDX_W-1:0] ptr_next;
   logic             emptied;

   assign rd_eff    = rd_fresh_ff ? FRESH_ENTRY : rd_data_ff;
   assign off       = round_up(rd_eff.fill);
   assign req_page  = req_free_addr[ADDR_W-1:PAGE_SHIFT];
   assign free_page = faddr_ff[ADDR_W-1:PAGE_SHIFT];
   assign ptr_next  = (32'(ptr_ff) == NUM_PAGES - 1) ? ptr_ff : IDX_W'(32'(ptr_ff) + 1);
   assign emptied   = (rd_eff.refs == REFS_W'(1));

   // Status toward the controller.
   always_comb begin
      dp_status.size_zero  = (size_ff == '0);
      dp_status.too_large  = !HEADER_FITS || (32'(size_ff) > MAX_ALLOC);
      dp_status.chain_done = (32'(ptr_ff) >= 32'(pages_used_ff));
      dp_status.fits       = (32'(off) <= PAGE_BYTES)
                             && ((PAGE_BYTES - 32'(off)) >= 32'(size_ff));
      dp_status.scan_last  = (32'(rd_idx_ff) + 1 >= 32'(pages_used_ff));
      dp_status.pool_full  = (32'(pages_used_ff) >= NUM_PAGES);
      dp_status.age_none   = (32'(search_start_ff) + 1 >= 32'(pages_used_ff));
      dp_status.age_last   = (32'(rd_idx_ff) + 2 >= 32'(pages_used_ff));
      dp_status.free_bad   = (32'(free_page) >= 32'(pages_used_ff))
                             || (32'(free_page) >= NUM_PAGES);
      dp_status.refs_zero  = (rd_eff.refs == '0);
      dp_status.clear_last = (32'(ptr_ff) + 1 >= 32'(pages_used_ff));
      dp_status.rsp_free   = !rsp_valid_ff || !rsp_stall;
   end

   // Write port selection.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = rd_idx_ff;
      wr_data = rd_eff;
      if (ctrl_cmd.hit_wr) begin
         wr_en = 1'b1;
         wr_data.fill = FILL_W'(off + OFF_W'(size_ff));
         wr_data.refs = (rd_eff.refs < REFS_MAX) ? rd_eff.refs + 1'b1 : rd_eff.refs;
      end else if (ctrl_cmd.age_wr) begin
         wr_en = 1'b1;
         wr_data.fails = (rd_eff.fails < FAILS_MAX) ? rd_eff.fails + 1'b1 : rd_eff.fails;
      end else if (ctrl_cmd.open_wr) begin
         wr_en   = 1'b1;
         wr_addr = IDX_W'(pages_used_ff);
         wr_data.fill  = FILL_W'(FIRST_OFF + 32'(size_ff));
         wr_data.refs  = REFS_W'(1);
         wr_data.fails = '0;
      end else if (ctrl_cmd.free_wr) begin
         wr_en = 1'b1;
         wr_data.refs = rd_eff.refs - 1'b1;
         if (emptied) begin
            wr_data.fill  = empty_fill(rd_idx_ff == '0);
            wr_data.fails = '0;
         end
      end else if (ctrl_cmd.clear_wr) begin
         wr_en   = 1'b1;
         wr_addr = ptr_ff;
         wr_data.fill  = empty_fill(ptr_ff == '0);
         wr_data.refs  = '0;
         wr_data.fails = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff  <= mem[ptr_ff];
      rd_idx_ff   <= ptr_ff;
      rd_fresh_ff <= page0_fresh_ff && (ptr_ff == '0);
   end

   // Walk pointer, request fields and result.
   always_ff @(posedge clock) begin
      if (ctrl_cmd.accept) begin
         size_ff       <= req_alloc_size;
         faddr_ff      <= req_free_addr;
         res_status_ff <= ST_OK;
         res_addr_ff   <= '0;
         case (req_command)
            CMD_ALLOC: ptr_ff <= search_start_ff;
            CMD_FREE:  ptr_ff <= (32'(req_page) < NUM_PAGES) ? IDX_W'(req_page) : '0;
            default:   ptr_ff <= '0;
         endcase
      end else if (ctrl_cmd.age_init) begin
         ptr_ff <= search_start_ff;
      end else if (ctrl_cmd.ptr_inc) begin
         ptr_ff <= ptr_next;
      end
      // The next search start follows the current one unless the aging walk moves it.
      if (ctrl_cmd.accept || ctrl_cmd.age_init) begin
         cur_ff <= search_start_ff;
      end else if (ctrl_cmd.age_wr && (32'(rd_eff.fails) > FAIL_LIMIT)) begin
         cur_ff <= IDX_W'(32'(rd_idx_ff) + 1);
      end
      if (ctrl_cmd.res_set) begin
         res_status_ff <= ctrl_cmd.res_code;
      end
      if (ctrl_cmd.hit_wr) begin
         res_addr_ff <= ADDR_W'(32'(rd_idx_ff) * PAGE_BYTES + 32'(off));
      end else if (ctrl_cmd.open_wr) begin
         res_addr_ff <= ADDR_W'(32'(pages_used_ff) * PAGE_BYTES + FIRST_OFF);
      end
   end

   // Chain state.
   always_ff @(posedge clock) begin
      if (reset) begin
         page0_fresh_ff  <= 1'b1;
         pages_used_ff   <= PU_W'(1);
         search_start_ff <= '0;
      end else begin
         if (wr_en && (wr_addr == '0)) begin
            page0_fresh_ff <= 1'b0;
         end
         if (ctrl_cmd.open_wr) begin
            pages_used_ff   <= pages_used_ff + 1'b1;
            search_start_ff <= cur_ff;
         end else if ((ctrl_cmd.free_wr && emptied) || ctrl_cmd.start_clr) begin
            search_start_ff <= '0;
         end
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl_cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl_cmd.rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_addr_ff   <= res_addr_ff;
         rsp_index_ff  <= INDEX_W'(search_start_ff);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_result_addr   = rsp_addr_ff;
   assign rsp_current_index = rsp_index_ff;

endmodule

>>> design/page_bump_allocator_core.sv
// ============================================================================
// page_bump_allocator_core: pool of fixed pages with bump allocation
// Top level joining the sequencing controller and the page table datapath.
// ============================================================================
// The block takes one command beat at a time: allocate, free or reset all
// pages. Each accepted beat yields exactly one response beat carrying a status,
// the granted address (zero unless an allocation succeeded) and the page where
// the next search starts. The page table sits in a memory with one read port
// and one write port, each handling one entry per cycle. A free reads the entry
// of its page and writes it back, a reset clears the pages in use one after
// another, and an allocation walks the pages from the search start until one
// has room; if none has and the pool is not full, it ages the walked pages
// but the newest and then opens a new one. The request side stalls while a
// command is in flight; a finished response waits in an output register, and
// the controller only holds while that register still holds a stalled beat.
// No clearing pass runs after reset: only the first page carries a reset
// value, and every other page is written when it opens.
module page_bump_allocator_core #(
   parameter int NUM_PAGES = pba_pkg::NUM_PAGES_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [pba_pkg::CMD_W-1:0]    req_command,
   input  logic [pba_pkg::SIZE_W-1:0]   req_alloc_size,
   input  logic [pba_pkg::ADDR_W-1:0]   req_free_addr,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [pba_pkg::STATUS_W-1:0] rsp_status,
   output logic [pba_pkg::ADDR_W-1:0]   rsp_result_addr,
   output logic [pba_pkg::INDEX_W-1:0]  rsp_current_index
);
   import pba_pkg::*;

   // Commands from the controller and conditions from the datapath.
   ctrl_cmd_type  ctrl_cmd;
   dp_status_type dp_status;

   // The controller owns the request handshake and decides every step.
   pba_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_command),
      .req_stall   (req_stall),
      .dp_status   (dp_status),
      .ctrl_cmd    (ctrl_cmd)
   );

   // The datapath owns the page table, chain state and the response register.
   pba_datapath #(
      .NUM_PAGES (NUM_PAGES)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_command       (req_command),
      .req_alloc_size    (req_alloc_size),
      .req_free_addr     (req_free_addr),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_result_addr   (rsp_result_addr),
      .rsp_current_index (rsp_current_index),
      .ctrl_cmd          (ctrl_cmd),
      .dp_status         (dp_status)
   );

endmodule

>>> design/pba_checker.sv
// ============================================================================
// pba_checker: port-level checks for the page bump allocator
// Watches the request and response ports over time and is bound to the top.
// ============================================================================
module pba_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [pba_pkg::STATUS_W-1:0] rsp_status,
   input logic [pba_pkg::ADDR_W-1:0]   rsp_result_addr,
   input logic [pba_pkg::INDEX_W-1:0]  rsp_current_index
);
   import pba_pkg::*;

   // A stalled response beat holds its contents.
   rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_result_addr) && $stable(rsp_current_index))
      else $error("response beat changed while stalled");

   // Only a successful allocation carries an address.
   err_addr_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |-> (rsp_result_addr == '0))
      else $error("failed command returned a nonzero address");

   // Reset leaves the block ready and with no response pending.
   reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("block not idle after reset");

   // An accepted command stalls the request side in the following cycle.
   accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request side not stalled after a command was accepted");

endmodule

bind page_bump_allocator_core pba_checker u_pba_checker (.*);

>>> test/tb_page_bump_allocator_core.sv
// ============================================================================
// tb_page_bump_allocator_core: self-checking bench for the page allocator
// Sends directed and random allocate, free and reset commands through the
// core. Request traffic comes in bursts and the response side applies
// backpressure. Every response beat is checked against a page table model
// kept inside the bench.
// ============================================================================
module tb_page_bump_allocator_core;
   timeunit 1ns;
   timeprecision 1ps;

   import pba_pkg::*;

   localparam int NUM_PAGES = NUM_PAGES_DEF;

   // The command field can carry a fourth code. The core must answer it
   // with a plain OK beat and leave the pool unchanged.
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   // Number of random commands that do real work. Unused-code beats are not
   // counted toward it.
   localparam int RANDOM_CMDS  = 1050;
   // Quiet cycles at the end, enough to outlast the slowest command and so
   // catch a stray response beat.
   localparam int DRAIN_CYCLES = 50;
   localparam int MAX_REPORTS  = 10;
   // Generator lookahead. Keeping it short lets the random free addresses
   // follow the live pages closely.
   localparam int LOOKAHEAD    = 4;

   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [SIZE_W-1:0] size;
      logic [ADDR_W-1:0] addr;
   } cmd_beat_type;

   typedef struct packed {
      status_type         status;
      logic [ADDR_W-1:0]  addr;
      logic [INDEX_W-1:0] next_page;
   } reply_beat_type;

   // Response backpressure patterns. The monitor moves between them at
   // random so that the stalls land on every phase of the core's work.
   typedef enum logic [1:0] {
      FLOW_OPEN,
      FLOW_SCATTER,
      FLOW_RUNS
   } flow_mode_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;

   logic                  req_valid      = 1'b0;
   logic                  req_stall;
   logic [CMD_W-1:0]      req_command    = '0;
   logic [SIZE_W-1:0]     req_alloc_size = '0;
   logic [ADDR_W-1:0]     req_free_addr  = '0;

   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [STATUS_W-1:0]   rsp_status;
   logic [ADDR_W-1:0]     rsp_result_addr;
   logic [INDEX_W-1:0]    rsp_current_index;

   // Commands waiting to be driven, and the replies expected from the core in
   // the order in which it must produce them.
   cmd_beat_type          pending_beats [$];
   reply_beat_type        expected_replies [$];

   int                    beats_sent;
   int                    beats_taken;
   int                    replies_seen;
   int                    mismatches;

   // Page table model. Pages 0 to open_pages-1 form the chain. scan_from is
   // the page where the next allocation search starts.
   logic [FILL_W-1:0]     fill_level [NUM_PAGES];
   logic [REFS_W-1:0]     live_refs  [NUM_PAGES];
   logic [FAILS_W-1:0]    miss_count [NUM_PAGES];
   int                    open_pages;
   int                    scan_from;

   // Driver and monitor working variables.
   int                    gap_left;
   int                    burst_left;
   int                    pg;
   cmd_beat_type          next_beat;
   cmd_beat_type          taken_beat;
   reply_beat_type        want;
   flow_mode_type         flow_mode;
   int                    mode_left;
   int                    stall_run;
   logic                  stall_hold;

   page_bump_allocator_core i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_command       (req_command),
      .req_alloc_size    (req_alloc_size),
      .req_free_addr     (req_free_addr),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_result_addr   (rsp_result_addr),
      .rsp_current_index (rsp_current_index)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Reset is synchronous. It is asserted once at the start, and never again.
   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
   end

   // Hard stop. The slowest correct run is about 1100 commands, each taking
   // the block's own time plus the longest sender gap and the longest
   // response stall. That comes to well under 0.4 ms, and this limit is
   // several times that.
   initial begin
      #1_500_000;
      $display("tb_page_bump_allocator_core NOT OK");
      $finish;
   end

   // Rounds a fill offset up to the allocation grain.
   function automatic int align_grain(input int n);
      return ((n + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
   endfunction

   // Returns a page to its empty state. The first page keeps its larger
   // header. An emptied page also forgets its failure history.
   function automatic void empty_page(input int p);
      fill_level[p] = (p == 0) ? FILL_W'(FIRST_HEADER) : FILL_W'(PAGE_HEADER);
      live_refs[p]  = '0;
      miss_count[p] = '0;
   endfunction

   // Applies one command beat to the page table model and returns the
   // response beat that the core must produce for it.
   function automatic reply_beat_type predict_reply(input cmd_beat_type b);
      reply_beat_type r;
      int          size;
      int          off;
      int          p;
      int          pick;
      bit          placed;
      r.status = ST_OK;
      r.addr   = '0;
      size     = int'(b.size);
      placed   = 1'b0;
      case (b.command)
         CMD_ALLOC: begin
            if (size == 0) begin
               r.status = ST_ZERO_SIZE;
            end else if (!HEADER_FITS || size > MAX_ALLOC) begin
               r.status = ST_TOO_LARGE;
            end else begin
               // Bump the first page, counted from the search start, that
               // has room after its fill offset is aligned.
               for (p = scan_from; p < open_pages && p < NUM_PAGES; p++) begin
                  off = align_grain(int'(fill_level[p]));
                  if (!placed && off <= PAGE_BYTES && PAGE_BYTES - off >= size) begin
                     placed = 1'b1;
                     if (live_refs[p] != REFS_MAX) live_refs[p]++;
                     fill_level[p] = FILL_W'(off + size);
                     r.addr        = ADDR_W'(p * PAGE_BYTES + off);
                  end
               end
               if (!placed) begin
                  if (open_pages >= NUM_PAGES) begin
                     r.status = ST_NO_PAGES;
                  end else begin
                     // Age every page walked except the newest one. A page
                     // that had already failed too often moves the search
                     // start past itself.
                     pick = scan_from;
                     for (p = scan_from; p + 1 < open_pages; p++) begin
                        if (miss_count[p] > FAIL_LIMIT) pick = p + 1;
                        if (miss_count[p] != FAILS_MAX) miss_count[p]++;
                     end
                     p             = open_pages;
                     fill_level[p] = FILL_W'(FIRST_OFF + size);
                     live_refs[p]  = REFS_W'(1);
                     miss_count[p] = '0;
                     open_pages++;
                     scan_from     = pick;
                     r.addr        = ADDR_W'(p * PAGE_BYTES + FIRST_OFF);
                  end
               end
            end
         end
         CMD_FREE: begin
            // Any address inside a page in use counts, the header included.
            p = int'(b.addr) / PAGE_BYTES;
            if (p >= open_pages || p >= NUM_PAGES || live_refs[p] == '0) begin
               r.status = ST_BAD_FREE;
            end else begin
               live_refs[p]--;
               if (live_refs[p] == '0) begin
                  empty_page(p);
                  scan_from = 0;
               end
            end
         end
         CMD_RESET: begin
            // The chain keeps its length. Only its contents are emptied.
            for (p = 0; p < open_pages && p < NUM_PAGES; p++) empty_page(p);
            scan_from = 0;
         end
         default: begin
         end
      endcase
      r.next_page = INDEX_W'(scan_from);
      return r;
   endfunction

   task automatic queue_beat(input logic [CMD_W-1:0] c, input int size, input int addr);
      cmd_beat_type b;
      b.command = c;
      b.size    = SIZE_W'(size);
      b.addr    = ADDR_W'(addr);
      pending_beats.push_back(b);
      beats_sent++;
   endtask

   // Request driver. Beats go out in bursts of random length with random
   // gaps between them. A beat that is not taken stays on the port unchanged
   // until the core takes it. The model is advanced at the edge at which a
   // beat is taken, so the expected replies line up with the core's order.
   always @(posedge clock) begin
      if (reset) begin
         req_valid  <= 1'b0;
         gap_left   = 0;
         burst_left = 1;
         for (pg = 0; pg < NUM_PAGES; pg++) begin
            fill_level[pg] = '0;
            live_refs[pg]  = '0;
            miss_count[pg] = '0;
         end
         fill_level[0] = FILL_W'(FIRST_HEADER);
         open_pages    = 1;
         scan_from     = 0;
      end else begin
         if (req_valid && !req_stall) begin
            taken_beat.command = req_command;
            taken_beat.size    = req_alloc_size;
            taken_beat.addr    = req_free_addr;
            expected_replies.push_back(predict_reply(taken_beat));
            beats_taken++;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left == 0 && pending_beats.size() != 0) begin
               next_beat = pending_beats.pop_front();
               req_valid      <= 1'b1;
               req_command    <= next_beat.command;
               req_alloc_size <= next_beat.size;
               req_free_addr  <= next_beat.addr;
               burst_left--;
               if (burst_left <= 0) begin
                  // Long bursts with no gap give stretches of back-to-back
                  // traffic. Short ones put idle cycles anywhere.
                  burst_left = $urandom_range(1) ? $urandom_range(40, 1) : $urandom_range(4, 1);
                  gap_left   = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(12, 1);
               end
            end else begin
               if (gap_left != 0) gap_left--;
               // The payload carries junk while the port is idle.
               req_valid      <= 1'b0;
               req_command    <= CMD_W'($urandom);
               req_alloc_size <= SIZE_W'($urandom);
               req_free_addr  <= ADDR_W'($urandom);
            end
         end
      end
   end

   // Response monitor and backpressure. Each beat taken is checked against
   // the oldest expected reply, field by field.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         flow_mode  = FLOW_OPEN;
         mode_left  = 0;
         stall_run  = 0;
         stall_hold = 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_replies.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("unexpected response beat: status %0d addr 0x%04h next page %0d",
                           rsp_status, rsp_result_addr, rsp_current_index);
            end else begin
               want = expected_replies.pop_front();
               if (rsp_status !== want.status || rsp_result_addr !== want.addr ||
                   rsp_current_index !== want.next_page) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS) begin
                     $write("response %0d: expected status %0d addr 0x%04h next page %0d,",
                            replies_seen, want.status, want.addr, want.next_page);
                     $display(" got status %0d addr 0x%04h next page %0d",
                              rsp_status, rsp_result_addr, rsp_current_index);
                  end
               end
            end
            replies_seen++;
         end

         // The backpressure pattern is picked anew at random: no stall at all,
         // scattered single stalls, or long runs of stall.
         if (mode_left == 0) begin
            flow_mode = flow_mode_type'($urandom_range(2, 0));
            mode_left = $urandom_range(300, 50);
         end else begin
            mode_left--;
         end
         case (flow_mode)
            FLOW_OPEN: begin
               rsp_stall <= 1'b0;
            end
            FLOW_SCATTER: begin
               rsp_stall <= ($urandom_range(3, 0) == 0);
            end
            default: begin
               if (stall_run == 0) begin
                  stall_hold = !stall_hold;
                  stall_run  = stall_hold ? $urandom_range(16, 1) : $urandom_range(8, 1);
               end else begin
                  stall_run--;
               end
               rsp_stall <= stall_hold;
            end
         endcase
      end
   end

   // Stimulus. A directed part walks the special cases and grows the chain
   // to its full length. A random part then mixes allocations, frees and
   // resets on the full pool.
   initial begin : stimulus_gen
      int        live_pages [$];
      int        roll;
      int        counted;
      int        p;
      bit        alloc_heavy;
      cmd_beat_type b;

      while (reset) @(posedge clock);

      // A free beyond the chain, and a free in the header of the idle
      // first page. Both must be rejected.
      queue_beat(CMD_FREE, $urandom, 16'hFFFF);
      queue_beat(CMD_FREE, $urandom, 16'h0010);
      // A zero size, the smallest size that is too large, the largest size
      // the field can hold, and the unused command code.
      queue_beat(CMD_ALLOC, 0, $urandom);
      queue_beat(CMD_ALLOC, MAX_ALLOC + 1, $urandom);
      queue_beat(CMD_ALLOC, (1 << SIZE_W) - 1, $urandom);
      queue_beat(CMD_UNUSED, $urandom, $urandom);
      // One byte on the first page: the fill offset past its header must be
      // aligned first.
      queue_beat(CMD_ALLOC, 1, $urandom);
      // Full-page allocations each open a new page. By the seventh open, the
      // first page has failed often enough to push the search start on.
      repeat (7) queue_beat(CMD_ALLOC, MAX_ALLOC, $urandom);
      // Emptying page 3 sends the search back to the first page. The refill
      // lands on page 3, and the next open ages the first page further, until its
      // failure count saturates.
      queue_beat(CMD_FREE, $urandom, 3 * PAGE_BYTES + 5);
      repeat (2) queue_beat(CMD_ALLOC, MAX_ALLOC, $urandom);
      queue_beat(CMD_FREE, $urandom, 4 * PAGE_BYTES - 1);
      repeat (2) queue_beat(CMD_ALLOC, MAX_ALLOC, $urandom);
      // Open the remaining pages, then ask for one more page than exists.
      repeat (7) queue_beat(CMD_ALLOC, MAX_ALLOC, $urandom);
      queue_beat(CMD_RESET, $urandom, $urandom);

      counted     = 0;
      alloc_heavy = 1'b1;
      while (counted < RANDOM_CMDS) begin
         while (pending_beats.size() >= LOOKAHEAD) @(posedge clock);
         // Phases that favor allocation fill the pool up to out-of-pages.
         // Phases that favor freeing drain pages back to empty.
         if (counted % 100 == 0) alloc_heavy = $urandom_range(1);
         b.command = CMD_UNUSED;
         b.size    = SIZE_W'($urandom);
         b.addr    = ADDR_W'($urandom);
         roll      = $urandom_range(99, 0);
         if (roll < 3) begin
            b.command = CMD_UNUSED;
         end else if (roll < 5) begin
            b.command = CMD_RESET;
         end else if (roll < (alloc_heavy ? 75 : 40)) begin
            b.command = CMD_ALLOC;
            roll      = $urandom_range(99, 0);
            if (roll < 40)      b.size = SIZE_W'($urandom_range(64, 1));
            else if (roll < 70) b.size = SIZE_W'($urandom_range(1024, 65));
            else if (roll < 85) b.size = SIZE_W'($urandom_range(MAX_ALLOC, 1025));
            else if (roll < 90) b.size = SIZE_W'(MAX_ALLOC);
            else if (roll < 94) b.size = '0;
            else if (roll < 97) b.size = SIZE_W'($urandom_range((1 << SIZE_W) - 1, MAX_ALLOC + 1));
         end else begin
            // Most frees land anywhere inside a page that still holds
            // blocks. The rest use a random address.
            b.command = CMD_FREE;
            live_pages.delete();
            for (p = 0; p < open_pages; p++)
               if (live_refs[p] != '0) live_pages.push_back(p);
            if (live_pages.size() != 0 && $urandom_range(9, 0) != 0)
               b.addr = ADDR_W'(live_pages[$urandom_range(live_pages.size() - 1, 0)] * PAGE_BYTES
                                + $urandom_range(PAGE_BYTES - 1, 0));
         end
         if (b.command != CMD_UNUSED) counted++;
         queue_beat(b.command, int'(b.size), int'(b.addr));
      end

      // Wait for the last beat to be taken and its reply to arrive. Then
      // watch a while longer for any stray response.
      while (beats_taken != beats_sent) @(posedge clock);
      while (expected_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb_page_bump_allocator_core OK");
      end else begin
         $display("tb_page_bump_allocator_core NOT OK");
      end
      $finish;
   end

endmodule

>>> page_bump_allocator_core.f
design/pba_pkg.sv
design/pba_ctrl.sv
design/pba_datapath.sv
design/page_bump_allocator_core.sv
design/pba_checker.sv
test/tb_page_bump_allocator_core.sv
